// ===== rtl/gww_pkg.sv =====
// Shared types and constants for the greedy word wrap block.
`default_nettype none

package gww_pkg;

   // Text codes the wrapper reacts to
   localparam logic [7:0] CHAR_NL  = 8'h0A;
   localparam logic [7:0] CHAR_SP  = 8'h20;
   localparam logic [7:0] CHAR_TAB = 8'h09;

   // Field widths
   localparam int BYTE_W = 8;
   localparam int CSR_W  = 6;

   // Line width after reset
   localparam logic [CSR_W-1:0] LINE_WIDTH_RESET = 6'd32;

   // Controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PICK,
      ST_SEND
   } ctl_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic accept;
      logic fetch;
      logic newline;
   } dp_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic has_a;
      logic has_brk;
      logic has_b;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== rtl/greedy_word_wrap.sv =====
// Top level of the greedy word wrapper: controller plus datapath.
`default_nettype none

// Greedy word wrapper. Text enters one byte per request and leaves wrapped
// to the width in the line_width register (zero acts as one, values above
// MAX_WIDTH act as MAX_WIDTH); a too-long line breaks at its latest space or
// tab, which is replaced by a newline, or is forced to break before the
// newest byte. One request is in work at a time: a new request is taken
// only once every result byte of the last one has left. Results leave at
// one byte per cycle while rsp_stall is low, set by the single read port of
// the line buffer memory, which holds up to MAX_WIDTH + 1 pending bytes.
// Write line_width only while idle.
module greedy_word_wrap #(
   parameter int MAX_WIDTH = 32
) (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           csr_valid,
   output logic                          csr_ready,
   input  wire  [gww_pkg::CSR_W-1:0]     csr_line_width,
   input  wire                           req_valid,
   output logic                          req_stall,
   input  wire  [gww_pkg::BYTE_W-1:0]    req_in_byte,
   input  wire                           req_in_end,
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output logic [gww_pkg::BYTE_W-1:0]    rsp_out_byte,
   output logic                          rsp_run_last,
   output logic                          rsp_text_end
);
   import gww_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   // Register writes are always taken
   assign csr_ready = 1'b1;

   gww_ctl u_ctl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   gww_dp #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_line_width (csr_line_width),
      .req_in_byte    (req_in_byte),
      .req_in_end     (req_in_end),
      .cmd            (cmd),
      .status         (status),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_text_end   (rsp_text_end)
   );

endmodule

`default_nettype wire

// ===== rtl/gww_ctl.sv =====
// Controller state machine: sequences request intake and byte emission.
`default_nettype none

module gww_ctl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire                    rsp_stall,
   input  gww_pkg::dp_status_type status,
   output gww_pkg::dp_cmd_type    cmd
);
   import gww_pkg::*;

   ctl_state_type state_ff;
   ctl_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      logic advance;
      advance   = 1'b0;
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_PICK;
            end
         end
         ST_PICK: begin
            advance = 1'b1;
         end
         ST_SEND: begin
            rsp_valid = 1'b1;
            advance   = !rsp_stall;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // Load the next result: head bytes, then break newline, then tail bytes
      if (advance) begin
         if (status.has_a) begin
            cmd.fetch = 1'b1;
            state_in  = ST_SEND;
         end else if (status.has_brk) begin
            cmd.newline = 1'b1;
            state_in    = ST_SEND;
         end else if (status.has_b) begin
            cmd.fetch = 1'b1;
            state_in  = ST_SEND;
         end else begin
            state_in = ST_IDLE;
         end
      end
   end

endmodule

`default_nettype wire

// ===== rtl/gww_dp.sv =====
// Datapath: line buffer ring, line state, emission plan and result register.
`default_nettype none

module gww_dp #(
   parameter int MAX_WIDTH = 32
) (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_valid,
   input  wire  [gww_pkg::CSR_W-1:0]           csr_line_width,
   input  wire  [gww_pkg::BYTE_W-1:0]          req_in_byte,
   input  wire                                 req_in_end,
   input  gww_pkg::dp_cmd_type                 cmd,
   output gww_pkg::dp_status_type              status,
   output logic [gww_pkg::BYTE_W-1:0]          rsp_out_byte,
   output logic                                rsp_run_last,
   output logic                                rsp_text_end
);
   import gww_pkg::*;

   localparam int DEPTH = MAX_WIDTH + 1;
   localparam int PW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int RING  = 1 << PW;

   // Line buffer ring
   logic [BYTE_W-1:0] mem [RING];
   logic [BYTE_W-1:0] mem_q_ff;

   // Line state
   logic [CSR_W-1:0]   line_width_ff;
   logic [PW-1:0]      head_ff, head_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [PW-1:0]      space_off_ff, space_off_in;
   logic               space_seen_ff, space_seen_in;

   // Emission plan
   logic [CW-1:0]      a_left_ff, a_left_in;
   logic [CW-1:0]      b_left_ff, b_left_in;
   logic               brk_ff, brk_in;
   logic               skip_ff, skip_in;
   logic               last_ff, last_in;

   // Result register
   logic               nl_sel_ff, nl_sel_in;
   logic               fin_ff, fin_in;

   // Plan terms
   logic               is_nl, is_sp;
   logic [CW-1:0]      weff;
   logic [PW-1:0]      cnt_c;
   logic [CW-1:0]      pcnt;
   logic [PW-1:0]      off_n;
   logic               seen_n;
   logic               over;
   logic               use_sp;
   logic [CW-1:0]      brk_len;
   logic [CW-1:0]      rem;
   logic [PW-1:0]      wr_addr;

   // Effective width: zero acts as one, saturate at MAX_WIDTH
   always_comb begin
      if (line_width_ff == '0) begin
         weff = CW'(1);
      end else if (int'(line_width_ff) > MAX_WIDTH) begin
         weff = CW'(MAX_WIDTH);
      end else begin
         weff = CW'(line_width_ff);
      end
   end

   // Plan the results of the incoming request
   always_comb begin
      is_nl  = (req_in_byte == CHAR_NL);
      is_sp  = (req_in_byte == CHAR_SP) || (req_in_byte == CHAR_TAB);
      cnt_c  = (int'(count_ff) >= DEPTH) ? PW'(DEPTH - 1) : PW'(count_ff);
      pcnt   = CW'(cnt_c) + CW'(1);
      seen_n = is_sp || space_seen_ff;
      off_n  = is_sp ? cnt_c : space_off_ff;
      over   = (pcnt > weff);
      use_sp = seen_n && (off_n != '0);
      brk_len = use_sp ? CW'(off_n) : (pcnt - CW'(1));
      if (over) begin
         rem = pcnt - brk_len - CW'(use_sp);
      end else begin
         rem = pcnt;
      end
      wr_addr = head_ff + cnt_c;
   end

   // Next state of line, plan and result registers
   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      space_off_in  = space_off_ff;
      space_seen_in = space_seen_ff;
      a_left_in     = a_left_ff;
      b_left_in     = b_left_ff;
      brk_in        = brk_ff;
      skip_in       = skip_ff;
      last_in       = last_ff;
      nl_sel_in     = nl_sel_ff;
      fin_in        = fin_ff;

      if (cmd.accept) begin
         last_in = req_in_end;
         if (is_nl) begin
            // flush the line, then the newline
            a_left_in     = count_ff;
            brk_in        = 1'b1;
            skip_in       = 1'b0;
            b_left_in     = '0;
            count_in      = '0;
            space_seen_in = 1'b0;
            space_off_in  = '0;
         end else begin
            if (over) begin
               a_left_in     = brk_len;
               brk_in        = 1'b1;
               skip_in       = use_sp;
               space_seen_in = 1'b0;
               space_off_in  = '0;
            end else begin
               a_left_in     = '0;
               brk_in        = 1'b0;
               skip_in       = 1'b0;
               space_seen_in = seen_n;
               space_off_in  = off_n;
            end
            if (req_in_end) begin
               b_left_in     = rem;
               count_in      = '0;
               space_seen_in = 1'b0;
               space_off_in  = '0;
            end else begin
               b_left_in = '0;
               count_in  = rem;
            end
         end
      end else if (cmd.fetch) begin
         // pop one buffered byte from the head
         head_in   = head_ff + PW'(1);
         nl_sel_in = 1'b0;
         if (a_left_ff != '0) begin
            a_left_in = a_left_ff - CW'(1);
            fin_in    = (a_left_ff == CW'(1)) && !brk_ff && (b_left_ff == '0);
         end else begin
            b_left_in = b_left_ff - CW'(1);
            fin_in    = (b_left_ff == CW'(1));
         end
      end else if (cmd.newline) begin
         // emit the break and drop the space it replaces
         head_in   = head_ff + PW'(skip_ff);
         brk_in    = 1'b0;
         nl_sel_in = 1'b1;
         fin_in    = (b_left_ff == '0);
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff <= LINE_WIDTH_RESET;
         head_ff       <= '0;
         count_ff      <= '0;
         space_off_ff  <= '0;
         space_seen_ff <= 1'b0;
         a_left_ff     <= '0;
         b_left_ff     <= '0;
         brk_ff        <= 1'b0;
         skip_ff       <= 1'b0;
         last_ff       <= 1'b0;
         nl_sel_ff     <= 1'b0;
         fin_ff        <= 1'b0;
      end else begin
         if (csr_valid) begin
            line_width_ff <= csr_line_width;
         end
         head_ff       <= head_in;
         count_ff      <= count_in;
         space_off_ff  <= space_off_in;
         space_seen_ff <= space_seen_in;
         a_left_ff     <= a_left_in;
         b_left_ff     <= b_left_in;
         brk_ff        <= brk_in;
         skip_ff       <= skip_in;
         last_ff       <= last_in;
         nl_sel_ff     <= nl_sel_in;
         fin_ff        <= fin_in;
      end
   end

   // Line buffer write and registered read
   always_ff @(posedge clock) begin
      if (cmd.accept && !is_nl) begin
         mem[wr_addr] <= req_in_byte;
      end
      if (cmd.fetch) begin
         mem_q_ff <= mem[head_ff];
      end
   end

   // Status and result fields
   assign status.has_a   = (a_left_ff != '0);
   assign status.has_brk = brk_ff;
   assign status.has_b   = (b_left_ff != '0);

   assign rsp_out_byte = nl_sel_ff ? CHAR_NL : mem_q_ff;
   assign rsp_run_last = fin_ff;
   assign rsp_text_end = fin_ff && last_ff;

endmodule

`default_nettype wire

// ===== test/greedy_word_wrap_tb.sv =====
// Self-checking testbench for the greedy word wrapper: directed and random text.
`timescale 1ns / 100ps

module tb;
   import gww_pkg::*;

   localparam int MAX_W       = 32;
   localparam int IDLE_PCT    = 18;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 22;
   localparam int SETTLE      = 8;
   localparam int HOLD_CYCLES = 150;
   localparam logic [7:0] LETTER_A = 8'h61;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              fin;
   } text_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              run_last;
      logic              text_end;
   } wrapped_type;

   logic                clock          = 1'b0;
   logic                reset          = 1'b1;
   logic                csr_valid      = 1'b0;
   logic                csr_ready;
   logic [CSR_W-1:0]    csr_line_width = '0;
   logic                req_valid      = 1'b0;
   logic                req_stall;
   logic [BYTE_W-1:0]   req_in_byte    = '0;
   logic                req_in_end     = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall      = 1'b0;
   logic [BYTE_W-1:0]   rsp_out_byte;
   logic                rsp_run_last;
   logic                rsp_text_end;

   // Text waiting to be sent and wrapped bytes waiting to be seen
   text_item_type text_q[$];
   wrapped_type   wrapped_q[$];
   int            queued_cnt = 0;
   int            taken_cnt  = 0;
   int            mismatches = 0;
   int            hold_left  = 0;
   int            cycle_cnt  = 0;
   logic          calm       = 1'b0;
   logic          req_busy   = 1'b0;
   logic          req_fired  = 1'b0;

   // Line state of the wrapper as predicted
   logic [BYTE_W-1:0] line_buf [0:MAX_W];
   int                line_len   = 0;
   int                brk_pos    = 0;
   logic              brk_seen   = 1'b0;
   logic [CSR_W-1:0]  wrap_width = LINE_WIDTH_RESET;

   greedy_word_wrap #(.MAX_WIDTH(MAX_W)) i_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_line_width (csr_line_width),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_in_byte    (req_in_byte),
      .req_in_end     (req_in_end),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_text_end   (rsp_text_end)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Work out the wrapped bytes that one request produces
   function automatic void wrap_byte(input logic [BYTE_W-1:0] c, input logic fin);
      wrapped_type run[$];
      int          w;
      int          cut;
      int          skip;
      int          i;
      w = wrap_width;
      if (w < 1) w = 1;
      if (w > MAX_W) w = MAX_W;
      if (c == CHAR_NL) begin
         for (i = 0; i < line_len; i++)
            run.push_back('{data: line_buf[i], run_last: 1'b0, text_end: 1'b0});
         run.push_back('{data: CHAR_NL, run_last: 1'b0, text_end: 1'b0});
         line_len = 0;
         brk_seen = 1'b0;
         brk_pos  = 0;
      end else begin
         if (line_len >= MAX_W + 1) line_len = MAX_W;
         line_buf[line_len] = c;
         if (c == CHAR_SP || c == CHAR_TAB) begin
            brk_seen = 1'b1;
            brk_pos  = line_len;
         end
         line_len++;
         // Overflow: break at the latest blank, or force a break before this byte
         if (line_len > w) begin
            if (brk_seen && brk_pos > 0 && brk_pos < line_len) begin
               cut  = brk_pos;
               skip = brk_pos + 1;
            end else begin
               cut  = line_len - 1;
               skip = line_len - 1;
            end
            for (i = 0; i < cut; i++)
               run.push_back('{data: line_buf[i], run_last: 1'b0, text_end: 1'b0});
            run.push_back('{data: CHAR_NL, run_last: 1'b0, text_end: 1'b0});
            if (skip >= line_len) begin
               line_len = 0;
            end else begin
               for (i = 0; i < line_len - skip; i++) line_buf[i] = line_buf[i + skip];
               line_len = line_len - skip;
            end
            brk_seen = 1'b0;
            brk_pos  = 0;
         end
      end
      // End of text: flush what is left of the line
      if (fin) begin
         for (i = 0; i < line_len; i++)
            run.push_back('{data: line_buf[i], run_last: 1'b0, text_end: 1'b0});
         line_len = 0;
         brk_seen = 1'b0;
         brk_pos  = 0;
      end
      if (run.size() > 0) begin
         run[run.size() - 1].run_last = 1'b1;
         run[run.size() - 1].text_end = fin;
      end
      foreach (run[i]) wrapped_q.push_back(run[i]);
   endfunction

   function automatic void log_mismatch(input wrapped_type exp_r, input wrapped_type got_r,
                                        input logic none_waiting);
      mismatches++;
      if (mismatches <= 10) begin
         if (none_waiting)
            $display("%0t: unexpected result byte=%h run_last=%b text_end=%b",
                     $realtime, got_r.data, got_r.run_last, got_r.text_end);
         else
            $display("%0t: expected byte=%h run_last=%b text_end=%b, got byte=%h %b %b",
                     $realtime, exp_r.data, exp_r.run_last, exp_r.text_end,
                     got_r.data, got_r.run_last, got_r.text_end);
      end
   endfunction

   // Predict on each accepted request, check each accepted result
   always @(posedge clock) begin : watch
      wrapped_type exp_r;
      wrapped_type got_r;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            wrap_byte(req_in_byte, req_in_end);
            taken_cnt++;
            req_fired = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            got_r = '{data: rsp_out_byte, run_last: rsp_run_last, text_end: rsp_text_end};
            if (wrapped_q.size() == 0) begin
               log_mismatch(got_r, got_r, 1'b1);
            end else begin
               exp_r = wrapped_q.pop_front();
               if (exp_r.data !== got_r.data || exp_r.run_last !== got_r.run_last ||
                   exp_r.text_end !== got_r.text_end)
                  log_mismatch(exp_r, got_r, 1'b0);
            end
         end
      end
   end

   // Offer queued text; hold each request until it is taken
   always @(negedge clock) begin : drive_text
      text_item_type nxt;
      logic          go;
      if (!reset) begin
         if (req_fired) begin
            req_fired = 1'b0;
            req_busy  = 1'b0;
         end
         if (!req_busy) begin
            go = text_q.size() > 0 && (calm || $urandom_range(99) >= IDLE_PCT);
            if (go) begin
               nxt = text_q.pop_front();
               req_in_byte <= nxt.data;
               req_in_end  <= nxt.fin;
               req_busy = 1'b1;
            end
            req_valid <= go;
         end
      end
   end

   // Stall results at random, or for a long hold when one is asked for
   always @(negedge clock) begin : drive_stall
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
   end

   initial begin : watchdog
      while (cycle_cnt < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_cnt++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   task automatic add_byte(input logic [BYTE_W-1:0] b, input logic fin);
      text_q.push_back('{data: b, fin: fin});
      queued_cnt++;
   endtask

   task automatic add_str(input string s, input logic close_text);
      int i;
      for (i = 0; i < s.len(); i++) add_byte(s[i], close_text && i == s.len() - 1);
   endtask

   // Words of random letters, blanks, newlines and some noise bytes
   task automatic add_random_text(input int n, input int max_word, input logic close_text);
      int k;
      int len;
      int pick;
      k = 0;
      while (k < n) begin
         pick = $urandom_range(99);
         if (pick < 68) begin
            len = $urandom_range(max_word, 1);
            repeat (len)
               add_byte(LETTER_A + 8'($urandom_range(25)), $urandom_range(99) < 2);
            k += len;
         end else begin
            if (pick < 82)      add_byte(CHAR_SP, 1'b0);
            else if (pick < 88) add_byte(CHAR_TAB, 1'b0);
            else if (pick < 93) add_byte(CHAR_NL, $urandom_range(99) < 5);
            else                add_byte(8'($urandom_range(255)), $urandom_range(99) < 5);
            k++;
         end
      end
      if (close_text) add_byte(LETTER_A + 8'($urandom_range(25)), 1'b1);
   endtask

   task automatic write_width(input logic [CSR_W-1:0] w);
      @(negedge clock);
      csr_valid      <= 1'b1;
      csr_line_width <= w;
      do @(posedge clock); while (!csr_ready);
      wrap_width = w;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Wait until every request is taken and every wrapped byte has come out
   task automatic wait_drained(input int settle);
      while (taken_cnt != queued_cnt || wrapped_q.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   initial begin : run_text
      logic [CSR_W-1:0] width_plan [12];
      logic [CSR_W-1:0] w;
      int               w_eff;
      int               max_word;
      int               ph;
      width_plan = '{6'd7, 6'd1, 6'd3, 6'd32, 6'd2, 6'd0, 6'd12, 6'd31, 6'd63, 6'd33,
                     6'd5, 6'd20};
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // Directed: reset width, then narrow lines with a leading blank, a tab,
      // a word too long for the line, zero width and an oversized width
      add_str("hi\n", 1'b0);
      add_byte(8'hFF, 1'b1);
      wait_drained(SETTLE);
      write_width(6'd4);
      add_str(" abcd e fgh\tij\n", 1'b0);
      add_byte(8'h00, 1'b1);
      wait_drained(SETTLE);
      write_width(6'd0);
      add_str("a b", 1'b1);
      wait_drained(SETTLE);
      write_width(6'd63);
      add_str("ok\n", 1'b1);
      wait_drained(SETTLE);

      // Random text over a range of widths; some phases stop mid-line so the
      // next width applies to a partly filled line
      for (ph = 0; ph < 12; ph++) begin
         w = (ph == 10) ? CSR_W'($urandom_range(63)) : width_plan[ph];
         w_eff = (w < 1) ? 1 : ((w > MAX_W) ? MAX_W : int'(w));
         max_word = ($urandom_range(3) == 0 || w_eff < 10) ? w_eff + 2 : 8;
         write_width(w);
         if (ph == 3) hold_left = HOLD_CYCLES;
         if (ph == 6) calm = 1'b1;
         add_random_text(PHASE_ITEMS, max_word, (ph % 3) != 1);
         wait_drained(SETTLE);
         calm = 1'b0;
      end

      wait_drained(40);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ===== greedy_word_wrap.f =====
rtl/gww_pkg.sv
rtl/gww_ctl.sv
rtl/gww_dp.sv
rtl/greedy_word_wrap.sv
test/greedy_word_wrap_tb.sv
